### sv/wmrd_pkg.sv
// Shared types, constants and helper functions for the windowed mismatch run detector.
// No dependencies; imported by every module of the block.
package wmrd_pkg;

    localparam int MAX_WIN      = 8;
    localparam int USED_BITS    = $clog2(MAX_WIN + 1);
    localparam int COUNT_BITS   = 24;
    localparam int POS_BITS     = 32;
    localparam int REG_BITS     = 24;
    localparam int FRAC_BITS    = REG_BITS;
    localparam int PROD_BITS    = REG_BITS + COUNT_BITS;
    localparam int BASE_BITS    = 8;
    localparam int IN_DATA_BITS = 2 * BASE_BITS;
    localparam int VERDICT_BITS = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam int OUT_FIELD_BITS = 2 * POS_BITS + 2 * COUNT_BITS + VERDICT_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    typedef logic [POS_BITS-1:0]     pos_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [REG_BITS-1:0]     reg_t;
    typedef logic [BASE_BITS-1:0]    base_t;
    typedef logic [VERDICT_BITS-1:0] verdict_t;
    typedef logic [USED_BITS-1:0]    used_t;

    localparam base_t  BASE_N    = base_t'(78);
    localparam count_t COUNT_MAX = '1;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_REGION = 1'b1;

    localparam verdict_t VERDICT_BELOW = 2'd0;
    localparam verdict_t VERDICT_ABOVE = 2'd1;
    localparam verdict_t VERDICT_NONE  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_OVERLAP = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_CUTOFF    = 2'd2;

    localparam reg_t RST_WINDOW_LENGTH  = reg_t'(500000);
    localparam reg_t RST_WINDOW_OVERLAP = reg_t'(400000);
    localparam reg_t RST_RATE_CUTOFF    = reg_t'(8389);

    typedef struct packed {
        reg_t window_length;
        reg_t window_overlap;
        reg_t rate_cutoff;
    } cfg_t;

    // One window close (or a bare end-of-sequence flush) handed to the record generator
    typedef struct packed {
        logic   flush_only;
        logic   fin;
        logic   last;
        pos_t   start_pos;
        pos_t   end_pos;
        count_t mismatches;
        count_t shared_called;
    } event_t;

    typedef struct packed {
        logic     kind;
        pos_t     start_pos;
        pos_t     end_pos;
        count_t   mismatches;
        count_t   shared_called;
        verdict_t verdict;
        logic     in_region_after;
        logic     last_result;
    } record_t;

    function automatic reg_t eff_length(reg_t len);
        return (len == '0) ? reg_t'(1) : len;
    endfunction

    function automatic reg_t eff_overlap(reg_t len, reg_t ovl);
        reg_t l;
        l = eff_length(len);
        return (ovl < l) ? ovl : reg_t'(l - reg_t'(1));
    endfunction

    // (p - s) mod 2^POS_BITS, plus one, reaches thr
    function automatic logic span_reaches(pos_t p, pos_t s, reg_t thr);
        logic [POS_BITS:0] d;
        d = {1'b0, pos_t'(p - s)} + (POS_BITS+1)'(1);
        return d >= {{(POS_BITS + 1 - REG_BITS){1'b0}}, thr};
    endfunction

    function automatic record_t make_region(pos_t s, pos_t e, logic last);
        record_t r;
        r.kind            = KIND_REGION;
        r.start_pos       = s;
        r.end_pos         = e;
        r.mismatches      = '0;
        r.shared_called   = '0;
        r.verdict         = VERDICT_BELOW;
        r.in_region_after = 1'b0;
        r.last_result     = last;
        return r;
    endfunction

endpackage

### sv/wmrd_window_bank.sv
// Open-window bank: a shift line of window cells, oldest at slot 0, with parallel counters.
// Emits one close event per cycle while draining, unless ev_ready stalls the event register. Depends on wmrd_pkg.
module wmrd_window_bank (
    input  logic            clk,
    input  logic            rst_n,
    input  wmrd_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  wmrd_pkg::base_t item_a,
    input  wmrd_pkg::base_t item_b,
    input  logic            item_fin,
    output logic            item_take,
    output logic            ev_valid,
    output wmrd_pkg::event_t ev,
    input  logic            ev_ready
);
    import wmrd_pkg::*;

    pos_t   start_reg [MAX_WIN];
    pos_t   start_next [MAX_WIN];
    count_t sh_reg [MAX_WIN];
    count_t sh_next [MAX_WIN];
    count_t mm_reg [MAX_WIN];
    count_t mm_next [MAX_WIN];
    logic [MAX_WIN-1:0] open_reg, open_next;
    used_t  used_reg, used_next;
    pos_t   pos_reg, pos_next;
    pos_t   nstart_reg, nstart_next;
    logic   drain_reg, drain_next;
    pos_t   cur_p_reg, cur_p_next;
    logic   fin_reg, fin_next;
    logic   ev_valid_reg, ev_valid_next;
    event_t ev_reg, ev_next;

    reg_t   len, ovl, step;
    logic   item_shared, item_diff;
    logic   open_new;
    logic   ev_slot_free;

    assign len         = eff_length(cfg.window_length);
    assign ovl         = eff_overlap(cfg.window_length, cfg.window_overlap);
    assign step        = len - ovl;
    assign item_shared = (item_a != BASE_N) && (item_b != BASE_N);
    assign item_diff   = item_shared && (item_a != item_b);
    assign item_take   = item_valid && !drain_reg;
    assign open_new    = (pos_reg == nstart_reg) && (used_reg < used_t'(MAX_WIN));
    assign ev_slot_free = !ev_valid_reg || ev_ready;
    assign ev_valid    = ev_valid_reg;
    assign ev          = ev_reg;

    always_comb
    begin
        reg_t thr;
        pos_t head_start;
        logic head_hit;
        logic q0;
        logic q1;

        start_next    = start_reg;
        sh_next       = sh_reg;
        mm_next       = mm_reg;
        open_next     = open_reg;
        used_next     = used_reg;
        pos_next      = pos_reg;
        nstart_next   = nstart_reg;
        drain_next    = drain_reg;
        cur_p_next    = cur_p_reg;
        fin_next      = fin_reg;
        ev_valid_next = ev_valid_reg && !ev_ready;
        ev_next       = ev_reg;
        thr           = fin_reg ? ovl : len;
        head_start    = '0;
        head_hit      = 1'b0;
        q0            = 1'b0;
        q1            = 1'b0;

        if (item_take)
        begin
            for (int i = 0; i < MAX_WIN; i++)
            begin
                if (open_reg[i])
                begin
                    if (item_shared && sh_reg[i] != COUNT_MAX)
                    begin
                        sh_next[i] = sh_reg[i] + count_t'(1);
                    end
                    if (item_diff && mm_reg[i] != COUNT_MAX)
                    begin
                        mm_next[i] = mm_reg[i] + count_t'(1);
                    end
                end
                else if (open_new && used_t'(i) == used_reg)
                begin
                    start_next[i] = pos_reg;
                    sh_next[i]    = count_t'(item_shared);
                    mm_next[i]    = count_t'(item_diff);
                    open_next[i]  = 1'b1;
                end
            end
            if (open_new)
            begin
                used_next = used_reg + used_t'(1);
            end
            if (pos_reg == nstart_reg)
            begin
                nstart_next = nstart_reg + {{(POS_BITS - REG_BITS){1'b0}}, step};
            end
            pos_next = pos_reg + pos_t'(1);

            // the close threshold only depends on positions, so decide here and drain later
            thr        = item_fin ? ovl : len;
            head_start = (used_reg == '0) ? pos_reg : start_reg[0];
            head_hit   = (open_reg[0] || open_new) && span_reaches(pos_reg, head_start, thr);
            if (head_hit || item_fin)
            begin
                drain_next = 1'b1;
                cur_p_next = pos_reg;
                fin_next   = item_fin;
            end
        end
        else if (drain_reg && ev_slot_free)
        begin
            q0 = open_reg[0] && span_reaches(cur_p_reg, start_reg[0], thr);
            q1 = open_reg[1] && span_reaches(cur_p_reg, start_reg[1], thr);
            ev_next.start_pos     = start_reg[0];
            ev_next.end_pos       = cur_p_reg + pos_t'(1);
            ev_next.mismatches    = mm_reg[0];
            ev_next.shared_called = sh_reg[0];
            ev_next.fin           = fin_reg;
            if (q0)
            begin
                ev_valid_next      = 1'b1;
                ev_next.flush_only = 1'b0;
                ev_next.last       = !q1;
                for (int i = 0; i < MAX_WIN - 1; i++)
                begin
                    start_next[i] = start_reg[i+1];
                    sh_next[i]    = sh_reg[i+1];
                    mm_next[i]    = mm_reg[i+1];
                end
                open_next = {1'b0, open_reg[MAX_WIN-1:1]};
                used_next = used_reg - used_t'(1);
            end
            else
            begin
                ev_valid_next      = fin_reg;
                ev_next.flush_only = 1'b1;
                ev_next.last       = 1'b1;
            end
            if (!q0 || !q1)
            begin
                drain_next = 1'b0;
                if (fin_reg)
                begin
                    // end of sequence: short tail windows are dropped
                    open_next   = '0;
                    used_next   = '0;
                    pos_next    = '0;
                    nstart_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        sh_reg    <= sh_next;
        mm_reg    <= mm_next;
        cur_p_reg <= cur_p_next;
        fin_reg   <= fin_next;
        ev_reg    <= ev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= '0;
            used_reg     <= '0;
            pos_reg      <= '0;
            nstart_reg   <= '0;
            drain_reg    <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg     <= open_next;
            used_reg     <= used_next;
            pos_reg      <= pos_next;
            nstart_reg   <= nstart_next;
            drain_reg    <= drain_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    a_open_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(open_reg) == 32'(used_reg))
        else $error("open window bits disagree with window count");

    a_open_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(open_reg + {{(MAX_WIN-1){1'b0}}, 1'b1}) || (open_reg == '1))
        else $error("open windows are not packed from slot 0");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_reg && !drain_next && fin_reg) |=> (used_reg == '0 && pos_reg == '0))
        else $error("sequence state not cleared after final base");

    a_no_take_with_pending_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_reg && ev_valid_reg && !ev_ready) |=> $stable(used_reg))
        else $error("window removed while close event was stalled");

endmodule

### sv/wmrd_record_gen.sv
// Record generator: mismatch-rate verdict, identical-run tracking and the output register.
// Turns each close event into up to three records. Depends on wmrd_pkg.
module wmrd_record_gen (
    input  logic              clk,
    input  logic              rst_n,
    input  wmrd_pkg::cfg_t    cfg,
    input  logic              ev_valid,
    input  wmrd_pkg::event_t  ev,
    output logic              ev_ready,
    output logic              rec_valid,
    output wmrd_pkg::record_t rec,
    input  logic              rec_ready
);
    import wmrd_pkg::*;

    // pending records in emit order: bit 0 region before, bit 1 window, bit 2 region after
    logic [2:0] pend_reg, pend_next;
    record_t    pre_reg, pre_next;
    record_t    win_reg, win_next;
    record_t    post_reg, post_next;
    logic       run_open_reg, run_open_next;
    pos_t       run_start_reg, run_start_next;
    logic       out_valid_reg, out_valid_next;
    record_t    out_reg, out_next;

    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] mm_scaled;
    logic                 ev_take;
    logic                 out_free;
    reg_t                 ovl;

    assign ovl       = eff_overlap(cfg.window_length, cfg.window_overlap);
    assign prod      = PROD_BITS'(cfg.rate_cutoff) * PROD_BITS'(ev.shared_called);
    assign mm_scaled = {ev.mismatches, {FRAC_BITS{1'b0}}};
    assign ev_ready  = (pend_reg == '0);
    assign ev_take   = ev_valid && ev_ready;
    assign out_free  = !out_valid_reg || rec_ready;
    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;

    always_comb
    begin
        verdict_t v;
        logic     open_after;
        pos_t     start_after;

        pend_next      = pend_reg;
        pre_next       = pre_reg;
        win_next       = win_reg;
        post_next      = post_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        out_valid_next = out_valid_reg && !rec_ready;
        out_next       = out_reg;
        v              = VERDICT_NONE;
        open_after     = run_open_reg;
        start_after    = run_start_reg;

        if (ev_take)
        begin
            if (ev.shared_called == '0)
            begin
                v = VERDICT_NONE;
            end
            else if (mm_scaled < prod)
            begin
                v = VERDICT_BELOW;
                if (!run_open_reg)
                begin
                    open_after  = 1'b1;
                    start_after = ev.start_pos;
                end
            end
            else
            begin
                v          = VERDICT_ABOVE;
                open_after = 1'b0;
            end

            pre_next = make_region(run_start_reg,
                ev.start_pos + {{(POS_BITS - REG_BITS){1'b0}}, ovl}, 1'b0);
            win_next.kind            = KIND_WINDOW;
            win_next.start_pos       = ev.start_pos;
            win_next.end_pos         = ev.end_pos;
            win_next.mismatches      = ev.mismatches;
            win_next.shared_called   = ev.shared_called;
            win_next.verdict         = v;
            win_next.in_region_after = open_after;
            win_next.last_result     = ev.last && !(ev.fin && open_after);

            if (ev.flush_only)
            begin
                post_next = make_region(run_start_reg, ev.end_pos, 1'b1);
                pend_next = {run_open_reg, 2'b00};
                run_open_next = 1'b0;
            end
            else
            begin
                // the region-after record is only sent with the last window of the final base
                post_next = make_region(start_after, ev.end_pos, 1'b1);
                pend_next = {ev.fin && ev.last && open_after, 1'b1,
                             (v == VERDICT_ABOVE) && run_open_reg};
                run_open_next  = open_after && !(ev.fin && ev.last);
                run_start_next = start_after;
            end
        end
        else if (pend_reg != '0 && out_free)
        begin
            out_valid_next = 1'b1;
            priority if (pend_reg[0])
            begin
                out_next    = pre_reg;
                pend_next[0] = 1'b0;
            end
            else if (pend_reg[1])
            begin
                out_next    = win_reg;
                pend_next[1] = 1'b0;
            end
            else
            begin
                out_next    = post_reg;
                pend_next[2] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg       <= pre_next;
        win_reg       <= win_next;
        post_reg      <= post_next;
        run_start_reg <= run_start_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            run_open_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            run_open_reg  <= run_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_region_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_REGION) |->
        (out_reg.mismatches == '0 && out_reg.shared_called == '0 && !out_reg.in_region_after))
        else $error("region record carries window fields");

    a_above_leaves_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_WINDOW && out_reg.verdict == VERDICT_ABOVE)
        |-> !out_reg.in_region_after)
        else $error("run still open after a window at or above the cutoff");

    a_none_no_shared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_WINDOW && out_reg.verdict == VERDICT_NONE)
        |-> (out_reg.shared_called == '0))
        else $error("no-shared verdict on a window with shared bases");

    a_fin_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_take && ev.fin && ev.last) |=> !run_open_reg)
        else $error("run left open past the final base");

endmodule

### sv/windowed_mismatch_run_detector.sv
// Top level of the windowed mismatch run detector: configuration registers, input register,
// window bank and record generator. Depends on wmrd_pkg, wmrd_window_bank, wmrd_record_gen.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: base_a, base_b; tlast: final_base
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: window/region record; tuser: kind;
//                                               tlast: last_result
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data (always ready)
//
// One base pair per cycle while the bank is not draining; after a base on which windows
// close, the bank drains them as one close event each, and the final base always drains.
// The record generator takes a close event only when no records are pending, then sends them.
// Reset puts all control state idle and loads default registers; no clearing pass.
// A stalled m_axis fills the output register, then the record generator, then the bank.
module windowed_mismatch_run_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [wmrd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,   // base_a [7:0], base_b [15:8]
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // start_pos, end_pos, mismatches, shared_called, verdict, in_region_after, zero pad
    output logic [wmrd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                                m_axis_tuser,   // kind
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wmrd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [wmrd_pkg::REG_BITS-1:0]       cfg_data
);
    import wmrd_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    base_t   in_a_reg;
    base_t   in_b_reg;
    logic    in_fin_reg;
    logic    item_take;
    logic    s_accept;
    logic    ev_valid;
    logic    ev_ready;
    event_t  ev;
    logic    rec_valid;
    record_t rec;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !in_valid_reg || item_take;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length  <= RST_WINDOW_LENGTH;
            cfg_reg.window_overlap <= RST_WINDOW_OVERLAP;
            cfg_reg.rate_cutoff    <= RST_RATE_CUTOFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH:  cfg_reg.window_length  <= cfg_data;
                CFG_WINDOW_OVERLAP: cfg_reg.window_overlap <= cfg_data;
                CFG_RATE_CUTOFF:    cfg_reg.rate_cutoff    <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_a_reg   <= s_axis_tdata[BASE_BITS-1:0];
            in_b_reg   <= s_axis_tdata[2*BASE_BITS-1:BASE_BITS];
            in_fin_reg <= s_axis_tlast;
        end
    end

    wmrd_window_bank u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (in_valid_reg),
        .item_a     (in_a_reg),
        .item_b     (in_b_reg),
        .item_fin   (in_fin_reg),
        .item_take  (item_take),
        .ev_valid   (ev_valid),
        .ev         (ev),
        .ev_ready   (ev_ready)
    );

    wmrd_record_gen u_recgen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .ev_ready  (ev_ready),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (m_axis_tready)
    );

    assign m_axis_tvalid = rec_valid;
    assign m_axis_tuser  = rec.kind;
    assign m_axis_tlast  = rec.last_result;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, rec.in_region_after, rec.verdict,
                            rec.shared_called, rec.mismatches, rec.end_pos, rec.start_pos};

endmodule
